@@ rtl/etlca_pkg.sv @@
// Shared types and helpers for the Euler-tour LCA engine.
package etlca_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // store one tour entry
        logic q_start;  // launch node position reads
        logic q_order;  // saturate and order the two positions
        logic q_k;      // pick the table level for the span
        logic q_tab;    // read the two overlapping table windows
        logic q_mode;   // tour read serves a query
        logic tour_rd;  // read depths of the two candidates
        logic b_start;  // set up the table build
        logic b_fin;    // mark the table valid if the tour is not empty
        logic b_tab;    // read the two halves from the level below
        logic b_cmp;    // pick the winner, write it, step
        logic q_out;    // load the answer into the output register
        logic nr_out;   // load a not-ready answer
    } etlca_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ready;     // table built
        logic lv_zero;   // build needs no levels
        logic j_one;     // building level one
        logic last_i;    // last position of the current level
        logic last_j;    // current level is the top one
        logic short_rng; // span of at most two positions
        logic out_full;  // output register holds a beat that is not being taken
    } etlca_sts_t;

    // Index of the highest set bit, zero for zero.
    function automatic logic [4:0] floor_log2(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int n = 1; n < 32; n++)
        begin
            if (x[n])
            begin
                r = 5'(n);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/euler_tour_lca_sparse_table_top.sv @@
// Top level of the Euler-tour / sparse-table lowest-common-ancestor engine.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser: cmd (0 load, 1 query); tlast: last tour entry;
//                tdata: entry_node, entry_level, query_u, query_v
// m_axis    out  tuser: not_ready; tdata: lca_node, lca_position
//
// A load beat is stored as it is taken; the beat marked tlast then starts a
// build of a setup step and a check that ends it when no level is needed,
// then per tour position on level one a tour read and a compare and write,
// and on each higher level a table read of both halves, a tour read and a
// compare and write, done once per tour. A query runs position read,
// ordering, level pick, table read, depth read, compare (no table read for a
// span of at most two positions); a not-ready one answers after position read.
// Reset clears lengths, build indices and flags only; memories are not cleared.
// A stalled m_axis holds one answer while the next input beat is taken.
module euler_tour_lca_sparse_table_top
    import etlca_pkg::*;
#(
    parameter int MAX_NODES  = 512,
    parameter int TOUR_DEPTH = 1024,
    parameter int LOG_LEVELS = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // entry_node, entry_level, query_u, query_v, zero pad
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // lca_node, lca_position, zero pad
    output logic        m_axis_tuser   // not_ready
);

    etlca_cmd_t ctl_cmd;
    etlca_sts_t dp_sts;
    logic [8:0] lca_node;
    logic [9:0] lca_position;

    etlca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    etlca_dp #(
        .MAX_NODES  (MAX_NODES),
        .TOUR_DEPTH (TOUR_DEPTH),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .sts         (dp_sts),
        .entry_node  (s_axis_tdata[8:0]),
        .entry_level (s_axis_tdata[17:9]),
        .query_u     (s_axis_tdata[26:18]),
        .query_v     (s_axis_tdata[35:27]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_node    (lca_node),
        .out_pos     (lca_position),
        .out_nr      (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b0, lca_position, lca_node};

    // table validity only drops on an accepted load beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(dp_sts.ready) |-> $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser))
        else $error("table ready dropped without a load");

    // a not-ready answer carries zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-ready beat with nonzero payload");

    // no input is taken while the build or a query is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(ctl_cmd.b_cmp || ctl_cmd.tour_rd || ctl_cmd.b_tab))
        else $error("input taken during build or query");

endmodule

@@ rtl/etlca_ctrl.sv @@
// Sequencer for loads, table build and queries of the LCA engine.
module etlca_ctrl
    import etlca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    input  logic       in_last,
    output logic       in_ready,
    input  etlca_sts_t sts,
    output etlca_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BSTART,
        S_BCHK,
        S_BTAB,
        S_BTOUR,
        S_BCMP,
        S_QORD,
        S_QK,
        S_QTAB,
        S_QTOUR,
        S_QCMP,
        S_NR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_cmd)
                    begin
                        cmd.load = 1'b1;
                        if (in_last)
                        begin
                            state_next = S_BSTART;
                        end
                    end
                    else
                    begin
                        cmd.q_start = 1'b1;
                        state_next  = sts.ready ? S_QORD : S_NR;
                    end
                end
            end
            S_BSTART:
            begin
                cmd.b_start = 1'b1;
                state_next  = S_BCHK;
            end
            S_BCHK:
            begin
                if (sts.lv_zero)
                begin
                    cmd.b_fin  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_BTOUR;
                end
            end
            S_BTAB:
            begin
                cmd.b_tab  = 1'b1;
                state_next = S_BTOUR;
            end
            S_BTOUR:
            begin
                cmd.tour_rd = 1'b1;
                state_next  = S_BCMP;
            end
            S_BCMP:
            begin
                cmd.b_cmp = 1'b1;
                if (sts.last_i && sts.last_j)
                begin
                    cmd.b_fin  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.last_i)
                begin
                    state_next = S_BTAB;
                end
                else
                begin
                    state_next = sts.j_one ? S_BTOUR : S_BTAB;
                end
            end
            S_QORD:
            begin
                cmd.q_order = 1'b1;
                state_next  = S_QK;
            end
            S_QK:
            begin
                cmd.q_k    = 1'b1;
                state_next = sts.short_rng ? S_QTOUR : S_QTAB;
            end
            S_QTAB:
            begin
                cmd.q_tab  = 1'b1;
                state_next = S_QTOUR;
            end
            S_QTOUR:
            begin
                cmd.tour_rd = 1'b1;
                cmd.q_mode  = 1'b1;
                state_next  = S_QCMP;
            end
            S_QCMP:
            begin
                if (!sts.out_full)
                begin
                    cmd.q_out  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NR:
            begin
                if (!sts.out_full)
                begin
                    cmd.nr_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/etlca_dp.sv @@
// Datapath of the LCA engine: tour, position and sparse-table memories.
module etlca_dp
    import etlca_pkg::*;
#(
    parameter int MAX_NODES  = 512,
    parameter int TOUR_DEPTH = 1024,
    parameter int LOG_LEVELS = 9
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  etlca_cmd_t cmd,
    output etlca_sts_t sts,
    input  logic [8:0] entry_node,
    input  logic [8:0] entry_level,
    input  logic [8:0] query_u,
    input  logic [8:0] query_v,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [8:0] out_node,
    output logic [9:0] out_pos,
    output logic       out_nr
);

    localparam int IDX_W     = (TOUR_DEPTH > 1) ? $clog2(TOUR_DEPTH) : 1;
    localparam int LEN_W     = $clog2(TOUR_DEPTH + 1);
    localparam int LV_W      = $clog2(LOG_LEVELS + 1);
    localparam int LI_W      = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int PN_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int TAB_DEPTH = LOG_LEVELS * (2 ** IDX_W);

    // tour entries stored as {depth, node}
    logic [17:0]      tour_mem [0:TOUR_DEPTH-1];
    logic [IDX_W-1:0] pos_mem  [0:MAX_NODES-1];
    logic [IDX_W-1:0] tab_mem  [0:TAB_DEPTH-1];

    logic [LEN_W-1:0] len_reg;
    logic [LV_W-1:0]  lv_reg;
    logic             ready_reg;
    logic [LV_W-1:0]  bj_reg;
    logic [IDX_W-1:0] bi_reg;
    logic             ri_ok_reg;
    logic [IDX_W-1:0] ca_reg;
    logic [IDX_W-1:0] cb_reg;
    logic             ok_reg;
    logic [17:0]      ta_q_reg;
    logic [17:0]      tb_q_reg;
    logic [IDX_W-1:0] ma_q_reg;
    logic [IDX_W-1:0] mb_q_reg;
    logic [IDX_W-1:0] pu_q_reg;
    logic [IDX_W-1:0] pv_q_reg;
    logic             u_ok_reg;
    logic             v_ok_reg;
    logic [IDX_W-1:0] qa_reg;
    logic [IDX_W-1:0] qb_reg;
    logic [IDX_W-1:0] diff_reg;
    logic             short_reg;
    logic [LV_W-1:0]  k_reg;
    logic             out_valid_reg;
    logic [8:0]       out_node_reg;
    logic [9:0]       out_pos_reg;
    logic             out_nr_reg;

    logic [LEN_W-1:0]     eff_len;
    logic [LEN_W:0]       half;
    logic [LEN_W:0]       ri_sum;
    logic [LEN_W-1:0]     i_plus1;
    logic [IDX_W-1:0]     ca_next;
    logic [IDX_W-1:0]     cb_next;
    logic                 ok_next;
    logic [LEN_W-1:0]     pu_sat;
    logic [LEN_W-1:0]     pv_sat;
    logic [LEN_W-1:0]     pu_raw;
    logic [LEN_W-1:0]     pv_raw;
    logic [4:0]           fl_len;
    logic [4:0]           fl_diff;
    logic [IDX_W-1:0]     w2_pos;
    logic                 a_wins;
    logic [LI_W+IDX_W-1:0] b_rda;
    logic [LI_W+IDX_W-1:0] b_rdb;
    logic [LI_W+IDX_W-1:0] q_rda;
    logic [LI_W+IDX_W-1:0] q_rdb;
    logic [LI_W+IDX_W-1:0] tab_wa;

    assign eff_len = ready_reg ? '0 : len_reg;
    assign half    = (LEN_W + 1)'(1) << (bj_reg - LV_W'(1));
    assign ri_sum  = (LEN_W + 1)'(bi_reg) + half;
    assign i_plus1 = LEN_W'(bi_reg) + LEN_W'(1);
    assign fl_len  = floor_log2(32'(len_reg));
    assign fl_diff = floor_log2(32'(diff_reg));

    assign pu_raw = u_ok_reg ? LEN_W'(pu_q_reg) : '0;
    assign pv_raw = v_ok_reg ? LEN_W'(pv_q_reg) : '0;
    assign pu_sat = (pu_raw >= len_reg) ? len_reg - LEN_W'(1) : pu_raw;
    assign pv_sat = (pv_raw >= len_reg) ? len_reg - LEN_W'(1) : pv_raw;

    assign w2_pos = qb_reg - IDX_W'((LEN_W + 1)'(1) << k_reg) + IDX_W'(1);
    assign b_rda  = {LI_W'(bj_reg - LV_W'(2)), bi_reg};
    assign b_rdb  = {LI_W'(bj_reg - LV_W'(2)), IDX_W'(ri_sum)};
    assign q_rda  = {LI_W'(k_reg - LV_W'(1)), qa_reg};
    assign q_rdb  = {LI_W'(k_reg - LV_W'(1)), w2_pos};
    assign tab_wa = {LI_W'(bj_reg - LV_W'(1)), bi_reg};

    // candidate pair for the depth compare
    always_comb
    begin
        if (cmd.q_mode)
        begin
            ca_next = short_reg ? qa_reg : ma_q_reg;
            cb_next = short_reg ? qb_reg : mb_q_reg;
            ok_next = 1'b1;
        end
        else if (bj_reg == LV_W'(1))
        begin
            ca_next = bi_reg;
            cb_next = IDX_W'(i_plus1);
            ok_next = (i_plus1 < len_reg);
        end
        else
        begin
            ca_next = ma_q_reg;
            cb_next = mb_q_reg;
            ok_next = ri_ok_reg;
        end
    end

    // earlier candidate wins on a strictly smaller depth or when the later one is out of range
    assign a_wins = !ok_reg || (ta_q_reg[17:9] < tb_q_reg[17:9]);

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && (eff_len < LEN_W'(TOUR_DEPTH)))
        begin
            tour_mem[IDX_W'(eff_len)] <= {entry_level, entry_node};
            if (32'(entry_node) < MAX_NODES)
            begin
                pos_mem[PN_W'(entry_node)] <= IDX_W'(eff_len);
            end
        end
        if (cmd.tour_rd)
        begin
            ta_q_reg <= tour_mem[ca_next];
            tb_q_reg <= tour_mem[cb_next];
        end
        if (cmd.q_start)
        begin
            pu_q_reg <= pos_mem[PN_W'(query_u)];
            pv_q_reg <= pos_mem[PN_W'(query_v)];
        end
        if (cmd.b_cmp)
        begin
            tab_mem[tab_wa] <= a_wins ? ca_reg : cb_reg;
        end
        if (cmd.b_tab)
        begin
            ma_q_reg <= tab_mem[b_rda];
            mb_q_reg <= tab_mem[b_rdb];
        end
        else if (cmd.q_tab)
        begin
            ma_q_reg <= tab_mem[q_rda];
            mb_q_reg <= tab_mem[q_rdb];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.tour_rd)
        begin
            ca_reg <= ca_next;
            cb_reg <= cb_next;
            ok_reg <= ok_next;
        end
        if (cmd.b_tab)
        begin
            ri_ok_reg <= (ri_sum < (LEN_W + 1)'(len_reg));
        end
        if (cmd.q_start)
        begin
            u_ok_reg <= (32'(query_u) < MAX_NODES);
            v_ok_reg <= (32'(query_v) < MAX_NODES);
        end
        if (cmd.q_order)
        begin
            if (pv_sat > pu_sat)
            begin
                qa_reg   <= IDX_W'(pu_sat);
                qb_reg   <= IDX_W'(pv_sat);
                diff_reg <= IDX_W'(pv_sat - pu_sat);
                short_reg <= (pv_sat - pu_sat) <= LEN_W'(1);
            end
            else
            begin
                qa_reg   <= IDX_W'(pv_sat);
                qb_reg   <= IDX_W'(pu_sat);
                diff_reg <= IDX_W'(pu_sat - pv_sat);
                short_reg <= (pu_sat - pv_sat) <= LEN_W'(1);
            end
        end
        if (cmd.q_k)
        begin
            k_reg <= (32'(fl_diff) > 32'(lv_reg)) ? lv_reg : LV_W'(fl_diff);
        end
        if (cmd.q_out)
        begin
            out_node_reg <= a_wins ? ta_q_reg[8:0] : tb_q_reg[8:0];
            out_pos_reg  <= 10'(a_wins ? ca_reg : cb_reg);
            out_nr_reg   <= 1'b0;
        end
        else if (cmd.nr_out)
        begin
            out_node_reg <= '0;
            out_pos_reg  <= '0;
            out_nr_reg   <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            lv_reg        <= '0;
            ready_reg     <= 1'b0;
            bj_reg        <= '0;
            bi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ready_reg <= 1'b0;
                if (ready_reg)
                begin
                    lv_reg <= '0;
                end
                if (eff_len < LEN_W'(TOUR_DEPTH))
                begin
                    len_reg <= eff_len + LEN_W'(1);
                end
                else
                begin
                    len_reg <= eff_len;
                end
            end
            if (cmd.b_start)
            begin
                lv_reg <= (32'(fl_len) > LOG_LEVELS) ? LV_W'(LOG_LEVELS) : LV_W'(fl_len);
                bj_reg <= LV_W'(1);
                bi_reg <= '0;
            end
            if (cmd.b_cmp)
            begin
                if (sts.last_i)
                begin
                    bi_reg <= '0;
                    bj_reg <= bj_reg + LV_W'(1);
                end
                else
                begin
                    bi_reg <= bi_reg + IDX_W'(1);
                end
            end
            if (cmd.b_fin)
            begin
                ready_reg <= (len_reg != '0);
            end
            if (cmd.q_out || cmd.nr_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.ready     = ready_reg;
    assign sts.lv_zero   = (lv_reg == '0);
    assign sts.j_one     = (bj_reg == LV_W'(1));
    assign sts.last_i    = (LEN_W'(bi_reg) == len_reg - LEN_W'(1));
    assign sts.last_j    = (bj_reg == lv_reg);
    assign sts.short_rng = short_reg;
    assign sts.out_full  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_pos   = out_pos_reg;
    assign out_nr    = out_nr_reg;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Euler-tour sparse-table LCA engine.
module testbench;
    import etlca_pkg::*;

    localparam int TOUR_MAX  = 1024;
    localparam int NODE_MAX  = 512;
    localparam int LVL_MAX   = 9;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TOTAL_BEATS = 1100;

    typedef struct packed {
        logic       cmd;
        logic       last;
        logic [8:0] node;
        logic [8:0] level;
        logic [8:0] qu;
        logic [8:0] qv;
    } beat_t;

    typedef struct packed {
        logic [8:0] node;
        logic [9:0] pos;
        logic       nr;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    euler_tour_lca_sparse_table_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the engine state
    logic [8:0] sh_node  [TOUR_MAX];
    logic [8:0] sh_level [TOUR_MAX];
    int         sh_pos   [NODE_MAX];
    int         sh_rmq   [LVL_MAX + 1][TOUR_MAX];
    int         sh_len;
    int         sh_levels;
    bit         sh_ready;

    beat_t   pending_beats[$];
    answer_t lca_expected[$];
    int      fail_count;
    int      cycle_count;
    bit      stim_done;
    bit      calm;          // no idling in the last part
    int      hold_cycles;   // long receiver hold-off

    // Generator-side bookkeeping of which nodes exist in the tour being built.
    int      gen_nodes[$];

    function automatic int log2_floor(input int x);
        int r;
        r = 0;
        while (x > 1)
        begin
            x = x >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic int shallower(input int a, input int b);
        return (sh_level[a] < sh_level[b]) ? a : b;
    endfunction

    task automatic build_sparse();
        int lv;
        int hw;
        lv = log2_floor(sh_len);
        if (lv > LVL_MAX)
            lv = LVL_MAX;
        sh_levels = lv;
        if (lv >= 1)
        begin
            for (int i = 0; i + 1 < sh_len; i++)
                sh_rmq[1][i] = shallower(i, i + 1);
            sh_rmq[1][sh_len - 1] = sh_len - 1;
        end
        for (int j = 2; j <= lv; j++)
        begin
            hw = 1 << (j - 1);
            for (int i = 0; i < sh_len; i++)
                sh_rmq[j][i] = (i + hw < sh_len) ?
                    shallower(sh_rmq[j - 1][i], sh_rmq[j - 1][i + hw]) : sh_rmq[j - 1][i];
        end
        sh_ready = (sh_len > 0);
    endtask

    function automatic int rep_position(input logic [8:0] n);
        int p;
        p = sh_pos[n];
        if (p >= sh_len)
            p = sh_len - 1;
        return p;
    endfunction

    // Applies one accepted beat to the shadow state; queues the answer, if any.
    task automatic predict_lca(input beat_t b);
        int a;
        int c;
        int t;
        int k;
        int p;
        answer_t r;
        if (b.cmd == CMD_LOAD)
        begin
            if (sh_ready)
            begin
                sh_len = 0;
                sh_levels = 0;
                sh_ready = 0;
            end
            if (sh_len < TOUR_MAX)
            begin
                sh_node[sh_len] = b.node;
                sh_level[sh_len] = b.level;
                sh_pos[b.node] = sh_len;
                sh_len++;
            end
            if (b.last)
                build_sparse();
        end
        else
        begin
            r = '0;
            if (!sh_ready)
                r.nr = 1'b1;
            else
            begin
                a = rep_position(b.qv);
                c = rep_position(b.qu);
                if (a > c)
                begin
                    t = a;
                    a = c;
                    c = t;
                end
                if (c - a <= 1)
                    p = shallower(a, c);
                else
                begin
                    k = log2_floor(c - a);
                    if (k > sh_levels)
                        k = sh_levels;
                    p = shallower(sh_rmq[k][a], sh_rmq[k][c - (1 << k) + 1]);
                end
                r.node = sh_node[p];
                r.pos = 10'(p);
            end
            lca_expected.push_back(r);
        end
    endtask

    function automatic beat_t mk_load(input int n, input int lv, input bit last);
        beat_t b;
        b = '0;
        b.cmd = CMD_LOAD;
        b.node = 9'(n);
        b.level = 9'(lv);
        b.last = last;
        b.qu = 9'($urandom);
        b.qv = 9'($urandom);
        return b;
    endfunction

    function automatic beat_t mk_query(input int u, input int v);
        beat_t b;
        b = '0;
        b.cmd = CMD_QUERY;
        b.qu = 9'(u);
        b.qv = 9'(v);
        b.node = 9'($urandom);
        b.level = 9'($urandom);
        b.last = $urandom_range(0, 1);
        return b;
    endfunction

    // Euler tour of a random tree with `cnt` nodes, random ids from a pool.
    task automatic push_tree(input int cnt, input bit random_levels);
        int ids[$];
        int stack[$];
        int nxt;
        int id;
        int lvl;
        ids.delete();
        gen_nodes.delete();
        nxt = $urandom_range(0, NODE_MAX - 1);
        for (int i = 0; i < cnt; i++)
            ids.push_back((nxt + i * 37) % NODE_MAX);
        stack.push_back(ids[0]);
        gen_nodes.push_back(ids[0]);
        nxt = 1;
        // tour: descend to a fresh child or return to parent
        forever
        begin
            id = stack[$];
            lvl = stack.size() - 1;
            if (random_levels)
                lvl = $urandom_range(0, 511);
            if (nxt < cnt && ($urandom_range(0, 2) != 0 || stack.size() == 1))
            begin
                pending_beats.push_back(mk_load(id, lvl, 0));
                stack.push_back(ids[nxt]);
                gen_nodes.push_back(ids[nxt]);
                nxt++;
            end
            else if (stack.size() > 1)
            begin
                pending_beats.push_back(mk_load(id, lvl, 0));
                void'(stack.pop_back());
            end
            else
            begin
                pending_beats.push_back(mk_load(id, lvl, 1));
                break;
            end
        end
    endtask

    function automatic int any_node();
        return gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Stimulus plan
    initial
    begin
        for (int i = 0; i < NODE_MAX; i++)
            sh_pos[i] = 0;
        sh_len = 0;
        sh_levels = 0;
        sh_ready = 0;
        fail_count = 0;
        calm = 0;
        // Directed: query before any build, with extreme ids
        pending_beats.push_back(mk_query(0, 511));
        pending_beats.push_back(mk_query(511, 0));
        // single-entry tour, then a query on it
        pending_beats.push_back(mk_load(511, 511, 1));
        gen_nodes.delete();
        gen_nodes.push_back(511);
        pending_beats.push_back(mk_query(511, 511));
        // two-entry tour with equal depths: tie goes to later index
        pending_beats.push_back(mk_load(0, 0, 0));
        pending_beats.push_back(mk_load(5, 0, 1));
        pending_beats.push_back(mk_query(0, 5));
        pending_beats.push_back(mk_query(5, 0));
        // node 511 is stale from the last tour; its old position still lies within the tour length
        pending_beats.push_back(mk_query(511, 0));
        // tour with depth extremes, built in full, then queries on it
        pending_beats.push_back(mk_load(1, 511, 0));
        pending_beats.push_back(mk_load(2, 0, 0));
        pending_beats.push_back(mk_load(3, 511, 0));
        pending_beats.push_back(mk_load(4, 255, 0));
        pending_beats.push_back(mk_load(510, 256, 1));
        pending_beats.push_back(mk_query(1, 510));
        pending_beats.push_back(mk_query(3, 4));
        pending_beats.push_back(mk_query(2, 2));
        // full tour: 1024 entries and one dropped beyond capacity, carrying last
        for (int i = 0; i < TOUR_MAX; i++)
            pending_beats.push_back(mk_load(i % NODE_MAX, $urandom_range(0, 511), 0));
        pending_beats.push_back(mk_load(7, 0, 1));
        gen_nodes.delete();
        for (int i = 0; i < NODE_MAX; i++)
            gen_nodes.push_back(i);
        for (int i = 0; i < 40; i++)
            pending_beats.push_back(mk_query(any_node(), any_node()));
        pending_beats.push_back(mk_query(0, 511));
        // Random: small well-formed trees and queries up to the beat budget
        while (pending_beats.size() < TOTAL_BEATS)
        begin
            push_tree($urandom_range(1, 24), $urandom_range(0, 3) == 0);
            for (int q = $urandom_range(4, 30); q > 0; q--)
                pending_beats.push_back(mk_query(any_node(), any_node()));
        end
    end

    // Driver
    int  src_gap;
    beat_t cur;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            s_axis_tuser  <= 1'b0;
            src_gap = 0;
            stim_done <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_lca(cur);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    cur = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur.cmd;
                    s_axis_tlast  <= cur.last;
                    s_axis_tdata  <= {4'b0, cur.qv, cur.qu, cur.level, cur.node};
                    if (!calm && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 6);
                    if (pending_beats.size() < 150)
                        calm <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // One long receiver hold-off right after reset, while the first queries
    // and loads keep being offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 400;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor and sink back-pressure
    int sink_gap;
    answer_t got;
    answer_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[8:0], m_axis_tdata[18:9], m_axis_tuser};
                if (lca_expected.size() == 0)
                begin
                    $display("%0t: unexpected answer %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = lca_expected.pop_front();
                    if (got.node !== want.node)
                    begin
                        $display("%0t: lca_node exp %0d got %0d", $time, want.node, got.node);
                        fail_count++;
                    end
                    if (got.pos !== want.pos)
                    begin
                        $display("%0t: lca_position exp %0d got %0d", $time, want.pos, got.pos);
                        fail_count++;
                    end
                    if (got.nr !== want.nr)
                    begin
                        $display("%0t: not_ready exp %0d got %0d", $time, want.nr, got.nr);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[euler_tour_lca_sparse_table_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && lca_expected.size() == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("[euler_tour_lca_sparse_table_top] OK");
        else
            $display("[euler_tour_lca_sparse_table_top] ERROR");
        $finish;
    end

endmodule
